// ===== hdl/alle_pkg.sv =====
// ----------------------------------------------------------------------------
// alle_pkg
// Shared types, codes and field widths of the array linked list engine.
// ----------------------------------------------------------------------------
package alle_pkg;

   // field widths of the stream payloads
   localparam int OP_BITS       = 3;
   localparam int POS_BITS      = 6;
   localparam int VALUE_IN_BITS = 32;
   localparam int LEN_BITS      = 7;
   localparam int STATUS_BITS   = 2;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 40;

   // parameter defaults
   localparam int SLOTS_DEFAULT      = 64;
   localparam int VALUE_BITS_DEFAULT = 32;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_BITS-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_BITS-1:0] OP_POP    = 3'd2;
   localparam logic [OP_BITS-1:0] OP_READ   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_WRITE  = 3'd4;

   // status codes
   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd3;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;  // open a gap at the target, shift the tail right
      logic write;   // overwrite the target cell
      logic probe;   // launch the target's value down the carry line
   } cell_cmd_type;

endpackage

// ===== hdl/alle_cell.sv =====
// ----------------------------------------------------------------------------
// alle_cell
// One list position: holds the element value and one stage of the carry
// line that moves a probed value toward the end of the chain.
// ----------------------------------------------------------------------------
module alle_cell #(
   parameter int SLOTS      = alle_pkg::SLOTS_DEFAULT,
   parameter int VALUE_BITS = alle_pkg::VALUE_BITS_DEFAULT,
   parameter int INDEX      = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  alle_pkg::cell_cmd_type      cmd,
   input  logic [$clog2(SLOTS)-1:0]    target_idx,
   input  logic [VALUE_BITS-1:0]       new_value,
   input  logic [VALUE_BITS-1:0]       left_value,
   input  logic [VALUE_BITS-1:0]       carry_in_value,
   input  logic                        carry_in_hit,
   output logic [VALUE_BITS-1:0]       value,
   output logic [VALUE_BITS-1:0]       carry_value,
   output logic                        carry_hit
);
   import alle_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [VALUE_BITS-1:0] carry_value_ff, carry_value_in;
   logic                  carry_hit_ff, carry_hit_in;
   logic                  is_target;

   assign is_target = (target_idx == MY_IDX);

   always_comb begin
      value_in = value_ff;
      if (cmd.insert) begin
         if (is_target) begin
            value_in = new_value;
         end else if (MY_IDX > target_idx) begin
            value_in = left_value;
         end
      end else if (cmd.write && is_target) begin
         value_in = new_value;
      end
   end

   always_comb begin
      if (cmd.probe && is_target) begin
         carry_value_in = value_ff;
         carry_hit_in   = 1'b1;
      end else begin
         carry_value_in = carry_in_value;
         carry_hit_in   = carry_in_hit;
      end
   end

   always_ff @(posedge clock) begin
      value_ff       <= value_in;
      carry_value_ff <= carry_value_in;
      if (reset) begin
         carry_hit_ff <= 1'b0;
      end else begin
         carry_hit_ff <= carry_hit_in;
      end
   end

   assign value       = value_ff;
   assign carry_value = carry_value_ff;
   assign carry_hit   = carry_hit_ff;

endmodule

// ===== hdl/array_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// array_linked_list_engine
// Singly linked list of value words kept as a row of position cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transaction is one request (append, insert after a
//   position, pop tail, read or write at a position). rsp channel: one
//   transaction per request with the value, the new length and a status.
//   Requests are taken one at a time; req_tready is high while the engine
//   is idle, also while an earlier response still waits in the output
//   register.
//   Append, insert, write, unknown codes and every failing request are
//   registered in the pending registers and then loaded into the output
//   register. Read and pop send the element value down the cell row, one
//   cell per cycle, from the position read (the tail for pop) until it
//   leaves the last cell. The next request is taken once the response is loaded.
//   Reset clears the length and the handshake state; the cell values are
//   left as they are and are only read below the length. No clearing pass.
//   A stalled rsp_tready holds the response; the engine finishes the next
//   request and waits until the output register is free.
// ----------------------------------------------------------------------------
module array_linked_list_engine #(
   parameter int SLOTS      = alle_pkg::SLOTS_DEFAULT,
   parameter int VALUE_BITS = alle_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [5:0] position, [37:6] value_in, [39:38] zero
   input  logic [alle_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // [2:0] operation
   input  logic [alle_pkg::OP_BITS-1:0]        req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] value_out, [38:32] list_length, [39] zero
   output logic [alle_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // [1:0] status
   output logic [alle_pkg::STATUS_BITS-1:0]    rsp_tuser
);
   import alle_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

   typedef enum logic [1:0] {IDLE, WALK, DONE} state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [VALUE_IN_BITS-1:0] pend_value_ff, pend_value_in;
   logic [LEN_BITS-1:0]      pend_len_ff, pend_len_in;
   logic [STATUS_BITS-1:0]   pend_status_ff, pend_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_IN_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [LEN_BITS-1:0]      rsp_len_ff, rsp_len_in;
   logic [STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;

   logic [OP_BITS-1:0]       req_op;
   logic [POS_BITS-1:0]      req_pos;
   logic [VALUE_IN_BITS-1:0] req_value;
   logic                     accept;
   logic [CMP_W-1:0]         pos_cmp, cnt_cmp, ins_cmp;
   logic                     is_full, is_empty, in_range;

   cell_cmd_type             cmd;
   logic [IDX_W-1:0]         target_idx;
   logic [VALUE_BITS-1:0]    new_value;

   logic [VALUE_BITS-1:0]    cell_value  [SLOTS];
   logic [VALUE_BITS-1:0]    carry_value [SLOTS];
   logic                     carry_hit   [SLOTS];

   assign req_op    = req_tuser;
   assign req_pos   = req_tdata[POS_BITS-1:0];
   assign req_value = req_tdata[POS_BITS +: VALUE_IN_BITS];

   assign req_tready = (state_ff == IDLE);
   assign accept     = req_tvalid && req_tready;

   assign pos_cmp  = CMP_W'(req_pos);
   assign cnt_cmp  = CMP_W'(count_ff);
   assign is_full  = (count_ff == CNT_W'(SLOTS));
   assign is_empty = (count_ff == '0);
   assign in_range = (pos_cmp < cnt_cmp);
   // insert after a position lands one further; past the end it appends
   assign ins_cmp  = in_range ? (pos_cmp + 1'b1) : cnt_cmp;
   assign new_value = VALUE_BITS'(req_value);

   // request decode and cell commands
   always_comb begin
      cmd            = '0;
      target_idx     = '0;
      count_in       = count_ff;
      pend_value_in  = pend_value_ff;
      pend_len_in    = pend_len_ff;
      pend_status_in = pend_status_ff;
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_value_in   = rsp_value_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_status_in  = rsp_status_ff;

      case (state_ff)
         IDLE: begin
            if (accept) begin
               pend_value_in  = '0;
               pend_status_in = ST_OK;
               state_in       = DONE;
               case (req_op)
                  OP_APPEND, OP_INSERT: begin
                     if (is_full) begin
                        pend_status_in = ST_FULL;
                     end else begin
                        cmd.insert = 1'b1;
                        target_idx = (req_op == OP_APPEND) ? IDX_W'(count_ff)
                                                           : IDX_W'(ins_cmp);
                        count_in   = count_ff + 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (is_empty) begin
                        pend_status_in = ST_EMPTY;
                     end else begin
                        cmd.probe  = 1'b1;
                        target_idx = IDX_W'(count_ff - 1'b1);
                        count_in   = count_ff - 1'b1;
                        state_in   = WALK;
                     end
                  end
                  OP_READ, OP_WRITE: begin
                     if (is_empty) begin
                        pend_status_in = ST_EMPTY;
                     end else if (!in_range) begin
                        pend_status_in = ST_RANGE;
                     end else begin
                        target_idx = IDX_W'(req_pos);
                        if (req_op == OP_READ) begin
                           cmd.probe = 1'b1;
                           state_in  = WALK;
                        end else begin
                           cmd.write = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               pend_len_in = LEN_BITS'(count_in);
            end
         end
         WALK: begin
            // the probed value leaves the last cell
            if (carry_hit[SLOTS-1]) begin
               pend_value_in = VALUE_IN_BITS'(carry_value[SLOTS-1]);
               state_in      = DONE;
            end
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = pend_value_ff;
               rsp_len_in    = pend_len_ff;
               rsp_status_in = pend_status_ff;
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pend_value_ff  <= pend_value_in;
      pend_len_ff    <= pend_len_in;
      pend_status_ff <= pend_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_len_ff     <= rsp_len_in;
      rsp_status_ff  <= rsp_status_in;
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // row of position cells, value shifts right on insert, probe runs right
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic [VALUE_BITS-1:0] left_value;
      logic [VALUE_BITS-1:0] carry_in_value;
      logic                  carry_in_hit;

      if (i == 0) begin : g_first
         assign left_value     = new_value;
         assign carry_in_value = '0;
         assign carry_in_hit   = 1'b0;
      end else begin : g_rest
         assign left_value     = cell_value[i-1];
         assign carry_in_value = carry_value[i-1];
         assign carry_in_hit   = carry_hit[i-1];
      end

      alle_cell #(
         .SLOTS      (SLOTS),
         .VALUE_BITS (VALUE_BITS),
         .INDEX      (i)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .cmd            (cmd),
         .target_idx     (target_idx),
         .new_value      (new_value),
         .left_value     (left_value),
         .carry_in_value (carry_in_value),
         .carry_in_hit   (carry_in_hit),
         .value          (cell_value[i]),
         .carry_value    (carry_value[i]),
         .carry_hit      (carry_hit[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_len_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== hdl/alle_checker.sv =====
// ----------------------------------------------------------------------------
// alle_checker
// Port-level checks of the array linked list engine, bound to the top level.
// ----------------------------------------------------------------------------
module alle_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [alle_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input logic [alle_pkg::OP_BITS-1:0]        req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [alle_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic [alle_pkg::STATUS_BITS-1:0]    rsp_tuser
);
   import alle_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // failed requests never return a value
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata[VALUE_IN_BITS-1:0] == '0))
      else $error("failed request returned a value");

   // one request in flight: the engine is busy right after a transaction
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind array_linked_list_engine alle_checker u_alle_checker (.*);
